FILE: rtl/core/psc_pkg.sv
// Shared constants and control types for the pair sum counter.
package psc_pkg;

    localparam int DEPTH = 1024;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_OUTER = 6'b000010,
        ST_INNER = 6'b000100,
        ST_WAIT  = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_EMIT  = 6'b100000
    } psc_state_t;

    typedef struct packed {
        logic store;
        logic clear;
        logic rd_outer;
        logic latch_want;
        logic start_inner;
        logic rd_inner;
        logic adv_outer;
        logic hit;
    } psc_cmd_t;

    typedef struct packed {
        logic last_outer;
        logic last_inner;
        logic empty;
        logic match;
    } psc_status_t;

endpackage

FILE: rtl/core/pair_sum_counter.sv
// Pair sum counter: top level with target register.
// Loads one value per beat while in load phase; the beat with last set starts
// a search that counts elements having a partner summing to target_sum at
// another position, and one result beat reports half that count. The search
// walks the store: it reads each outer element, latches the partner value it
// wants, then reads and compares inner entries until a match or the last one.
// Values beyond 1024 are dropped and flagged by overflow.
module pair_sum_counter
    import psc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic signed [31:0] cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] value,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [9:0]         pair_count,
    output logic               overflow
);

    logic signed [31:0] target_reg;
    psc_cmd_t           cmd;
    psc_status_t        status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= '0;
        else if (cfg_we)
            target_reg <= cfg_wdata;
    end

    psc_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (last),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    psc_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .target_reg (target_reg),
        .cmd        (cmd),
        .status     (status),
        .pair_count (pair_count),
        .overflow   (overflow)
    );

endmodule

FILE: rtl/core/psc_datapath.sv
// Datapath: value store, fill count, match counter and comparator.
module psc_datapath
    import psc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] value,
    input  logic signed [31:0] target_reg,
    input  psc_cmd_t           cmd,
    output psc_status_t        status,
    output logic [9:0]         pair_count,
    output logic               overflow
);

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] fill_reg;
    logic          drop_reg;
    logic [AW-1:0] i_reg;
    logic [AW-1:0] j_reg;
    logic [AW-1:0] jd_reg;
    logic [CW-1:0] hits_reg;
    logic signed [32:0] want_reg;
    logic [CW-1:0] half;

    assign rd_addr = cmd.rd_outer ? i_reg : j_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.store && fill_reg < CW'(DEPTH))
        begin
            mem[fill_reg[AW-1:0]] <= value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            drop_reg <= 1'b0;
            i_reg    <= '0;
            j_reg    <= '0;
            jd_reg   <= '0;
            hits_reg <= '0;
            want_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                fill_reg <= '0;
                drop_reg <= 1'b0;
                i_reg    <= '0;
                hits_reg <= '0;
            end
            else if (cmd.store)
            begin
                if (fill_reg < CW'(DEPTH))
                    fill_reg <= fill_reg + 1'b1;
                else
                    drop_reg <= 1'b1;
            end
            if (cmd.latch_want)
                want_reg <= 33'(target_reg) - 33'(signed'(rd_data_reg));
            if (cmd.start_inner)
                j_reg <= '0;
            else if (cmd.rd_inner)
            begin
                jd_reg <= j_reg;
                j_reg  <= j_reg + 1'b1;
            end
            if (cmd.adv_outer)
                i_reg <= i_reg + 1'b1;
            if (cmd.hit)
                hits_reg <= hits_reg + 1'b1;
        end
    end

    assign status.empty      = (fill_reg == '0);
    assign status.last_outer = (CW'(i_reg) + 1'b1 == fill_reg);
    assign status.last_inner = (CW'(j_reg) + 1'b1 == fill_reg);
    assign status.match      = (jd_reg != i_reg) &&
                               (33'(signed'(rd_data_reg)) == want_reg);

    assign half       = hits_reg >> 1;
    assign pair_count = (half > CW'(1023)) ? 10'd1023 : half[9:0];
    assign overflow   = drop_reg;

endmodule

FILE: rtl/core/psc_control.sv
// Controller: sequences the load phase and the nested match search.
module psc_control
    import psc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  psc_status_t status,
    output psc_cmd_t    cmd
);

    psc_state_t state_reg, state_next;
    logic       inner_last_reg, inner_last_next;
    logic       acc;

    assign in_stall  = (state_reg != ST_LOAD);
    assign out_valid = (state_reg == ST_EMIT);
    assign acc       = in_valid && !in_stall;

    always_comb
    begin
        cmd             = '0;
        state_next      = state_reg;
        inner_last_next = inner_last_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.store = acc;
                if (acc && in_last)
                    state_next = ST_OUTER;
            end
            ST_OUTER:
            begin
                if (status.empty)
                    state_next = ST_EMIT;
                else
                begin
                    cmd.rd_outer    = 1'b1;
                    cmd.start_inner = 1'b1;
                    state_next      = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                cmd.latch_want = 1'b1;
                state_next     = ST_INNER;
            end
            ST_INNER:
            begin
                // read one inner entry; compare it in the next cycle
                cmd.rd_inner    = 1'b1;
                inner_last_next = status.last_inner;
                state_next      = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.match)
                begin
                    cmd.hit = 1'b1;
                    if (status.last_outer)
                        state_next = ST_EMIT;
                    else
                    begin
                        cmd.adv_outer = 1'b1;
                        state_next    = ST_OUTER;
                    end
                end
                else if (inner_last_reg)
                begin
                    if (status.last_outer)
                        state_next = ST_EMIT;
                    else
                    begin
                        cmd.adv_outer = 1'b1;
                        state_next    = ST_OUTER;
                    end
                end
                else
                    state_next = ST_INNER;
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            inner_last_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            inner_last_reg <= inner_last_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hit |-> state_reg == ST_CHECK)
        else $error("hit outside check");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !cmd.clear)
        else $error("store and clear together");

endmodule
